// ===== hdl/ets_pkg.sv =====
// shared types and constants of the event timer scheduler
`timescale 1ns / 1ps

package ets_pkg;

  localparam int DEVICES    = 16;
  localparam int CYCLE_BITS = 48;
  localparam int IDX_W      = $clog2(DEVICES);
  localparam int CNT_W      = $clog2(DEVICES + 1);
  localparam int MASK_W     = 16;

  localparam logic [CYCLE_BITS-1:0] NEVER = '1;

  localparam logic [1:0] OP_SCHEDULE = 2'd0;
  localparam logic [1:0] OP_CANCEL   = 2'd1;
  localparam logic [1:0] OP_RUN      = 2'd2;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [3:0]            device_index;
    logic [CYCLE_BITS-1:0] cycle_value;
  } in_item_t;

  typedef struct packed {
    logic                  dispatched;
    logic [3:0]            fired_device;
    logic [CYCLE_BITS-1:0] fire_time;
    logic                  last;
    logic [CYCLE_BITS-1:0] current_time;
    logic [CYCLE_BITS-1:0] earliest_due;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

endpackage

// ===== hdl/event_timer_scheduler_core.sv =====
// event timer scheduler: due-time memory, scan sequencer and result register
`timescale 1ns / 1ps

// Usage
// - in_valid / in_stall carry one operation per transaction: schedule a
//   due time for a device slot, cancel a slot, or run until a deadline
// - out_valid / out_stall carry results; every operation ends with one
//   summary result (last = 1); run-until first gives one result per fired
//   event of a bound device, earliest first, ties to the lower device
// - cfg_valid / cfg_ready write bound_mask; cfg_ready is always high; the user
//   must write only while the block is idle; the block does not enforce it
// - each slot's due time lives in a 16-entry memory with registered read;
//   every pass over the memory (one read a cycle) finds the earliest
//   pending event and is followed by a decide step
// - schedule and cancel: one pass, then the summary; the next transaction
//   can be taken as soon as the summary sits in the output register
// - run-until with k fired events: k + 1 passes, each with its decide step,
//   plus a further decide step for each reported event
// - one operation is in work at a time; in_stall is high until its summary
//   sits in the output register, while a result already there may wait
// - a stalled output holds the sequencer in its decide step; nothing is lost
// - reset (synchronous, rst_n low) clears all valid bits, so every slot
//   reads as never due, now to zero and bound_mask to zero; no clearing pass
module event_timer_scheduler_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ets_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ets_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);

  import ets_pkg::*;

  // due-time memory, one entry per device slot
  logic [CYCLE_BITS-1:0] due_mem [DEVICES];
  logic [CYCLE_BITS-1:0] mem_q_r;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_wa;
  logic [CYCLE_BITS-1:0] mem_wd;
  logic [IDX_W-1:0]      mem_ra;

  // sequencer state
  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CYCLE_BITS-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]      pick_r, pick_nxt;
  logic [CYCLE_BITS-1:0] now_r, now_nxt;
  logic [CYCLE_BITS-1:0] dl_r, dl_nxt;
  logic                  run_r, run_nxt;
  logic                  pend_r, pend_nxt;
  logic [IDX_W-1:0]      pend_dev_r, pend_dev_nxt;
  logic [CYCLE_BITS-1:0] pend_time_r, pend_time_nxt;
  logic [DEVICES-1:0]    vld_r, vld_nxt;
  logic [MASK_W-1:0]     bound_r;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  out_free;
  logic                  in_take;
  logic [IDX_W-1:0]      cmp_idx;
  logic [CYCLE_BITS-1:0] cmp_val;
  logic                  fire;
  logic [CYCLE_BITS-1:0] end_now;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // entry under compare is the one read the cycle before
  assign cmp_idx = IDX_W'(cnt_r - CNT_W'(1));
  assign cmp_val = vld_r[cmp_idx] ? mem_q_r : NEVER;

  // earliest pending event lies inside the deadline
  assign fire    = run_r && (best_r != NEVER) && (best_r <= dl_r);
  assign end_now = run_r ? dl_r : now_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    best_nxt      = best_r;
    pick_nxt      = pick_r;
    now_nxt       = now_r;
    dl_nxt        = dl_r;
    run_nxt       = run_r;
    pend_nxt      = pend_r;
    pend_dev_nxt  = pend_dev_r;
    pend_time_nxt = pend_time_r;
    vld_nxt       = vld_r;
    mem_we        = 1'b0;
    mem_wa        = in_data.device_index[IDX_W-1:0];
    mem_wd        = (in_data.cycle_value < now_r) ? now_r : in_data.cycle_value;
    mem_ra        = cnt_r[IDX_W-1:0];
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          run_nxt  = (in_data.opcode == OP_RUN) && (in_data.cycle_value > now_r);
          dl_nxt   = in_data.cycle_value;
          cnt_nxt  = '0;
          best_nxt = NEVER;
          pick_nxt = '0;
          unique case (in_data.opcode)
            OP_SCHEDULE: begin
              if (32'(in_data.device_index) < DEVICES) begin
                mem_we          = 1'b1;
                vld_nxt[mem_wa] = 1'b1;
              end
            end
            OP_CANCEL: begin
              if (32'(in_data.device_index) < DEVICES) begin
                vld_nxt[mem_wa] = 1'b0;
              end
            end
            default: begin
            end
          endcase
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // strict compare keeps the lower index on ties
        if (cnt_r != '0 && cmp_val < best_r) begin
          best_nxt = cmp_val;
          pick_nxt = cmp_idx;
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DEVICES)) begin
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        priority if (pend_r) begin
          // report the previous fired event, earliest taken after its clear
          if (out_free) begin
            out_valid_nxt             = 1'b1;
            out_data_nxt.dispatched   = 1'b1;
            out_data_nxt.fired_device = 4'(pend_dev_r);
            out_data_nxt.fire_time    = pend_time_r;
            out_data_nxt.last         = 1'b0;
            out_data_nxt.current_time = now_r;
            out_data_nxt.earliest_due = best_r;
            pend_nxt                  = 1'b0;
          end
        end else if (fire) begin
          now_nxt          = best_r;
          vld_nxt[pick_r]  = 1'b0;
          pend_nxt         = bound_r[pick_r];
          pend_dev_nxt     = pick_r;
          pend_time_nxt    = best_r;
          cnt_nxt          = '0;
          best_nxt         = NEVER;
          pick_nxt         = '0;
          state_nxt        = ST_SCAN;
        end else begin
          if (out_free) begin
            out_valid_nxt             = 1'b1;
            out_data_nxt.dispatched   = 1'b0;
            out_data_nxt.fired_device = '0;
            out_data_nxt.fire_time    = '0;
            out_data_nxt.last         = 1'b1;
            out_data_nxt.current_time = end_now;
            out_data_nxt.earliest_due = best_r;
            now_nxt                   = end_now;
            run_nxt                   = 1'b0;
            state_nxt                 = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      run_r       <= 1'b0;
      pend_r      <= 1'b0;
      vld_r       <= '0;
      bound_r     <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      now_r       <= now_nxt;
      run_r       <= run_nxt;
      pend_r      <= pend_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        bound_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    best_r      <= best_nxt;
    pick_r      <= pick_nxt;
    dl_r        <= dl_nxt;
    pend_dev_r  <= pend_dev_nxt;
    pend_time_r <= pend_time_nxt;
    out_data_r  <= out_data_nxt;
  end

  // due-time memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      due_mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= due_mem[mem_ra];
  end

  // an accepted operation always starts a pass over the memory
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r == ST_SCAN)
    else $error("accepted operation did not start a scan");

  // a reported event fired at the time now holds in that result
  a_fire_now: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.dispatched |->
      out_data_r.current_time == out_data_r.fire_time)
    else $error("dispatched result with mismatching current time");

  // a result is either an event report or the summary, never both
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.dispatched != out_data_r.last)
    else $error("result is neither or both of event and summary");

  // no pending report is left behind when the block goes idle
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r != ST_IDLE)
    else $error("pending event report while idle");

  // now only moves forward inside a run
  a_now_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DECIDE && fire && !pend_r |=> now_r >= $past(now_r))
    else $error("current time moved backward");

endmodule
